// ===== sv/wbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbe_pkg
// shared constants, types, weight table and microcode word for the
// weighted bandwidth estimator
// ----------------------------------------------------------------------------
package wbe_pkg;

	// history ring
	localparam int WBE_DEPTH = 5;
	localparam int SLOT_W    = (WBE_DEPTH > 1) ? $clog2(WBE_DEPTH) : 1;
	localparam int CNT_W     = $clog2(WBE_DEPTH + 1);

	// field widths
	localparam int BYTES_W = 28;
	localparam int NS_W    = 40;
	localparam int RATE_W  = 32;
	localparam int CFG_W   = 32;

	// rate numerator: bytes * 1e9, then << 3 for bits
	localparam int                NSPS_W   = 30;
	localparam logic [NSPS_W-1:0] NS_PER_S = 30'd1_000_000_000;
	localparam int                PROD_W   = BYTES_W + NSPS_W;

	// weights e^(1-i) in q16
	localparam int WT_N     = 16;
	localparam int WT_IDX_W = 4;
	localparam int WT_W     = 18;
	localparam int DEN_W    = 19;
	localparam int MPROD_W  = RATE_W + WT_W;
	localparam int ACC_W    = RATE_W + DEN_W;

	// shared restoring divider
	localparam int                DIV_STEPS = 32;
	localparam int                DCNT_W    = 6;
	localparam logic [DCNT_W-1:0] DCNT_INIT = DCNT_W'(DIV_STEPS);

	// configuration
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINK_SPEED_CAP = 1'b0,
		CFG_MAX_RATE_CAP   = 1'b1
	} cfg_idx_t;

	// microcode
	localparam int PC_W = 4;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_MUL_RATE,
		OP_RATE_SETUP,
		OP_DIV_STEP,
		OP_PUSH,
		OP_MAC_MUL,
		OP_MAC_ADD,
		OP_MEAN_SETUP,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_IF_NO_IN,
		JC_IF_SAT,
		JC_IF_DIV_MORE,
		JC_IF_MAC_MORE,
		JC_IF_OUT_BUSY
	} jc_t;

	typedef struct packed {
		op_t             op;
		jc_t             jc;
		logic [PC_W-1:0] target;
	} ucode_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic in_pending;
		logic rate_sat;
		logic div_more;
		logic mac_more;
		logic out_busy;
	} stat_t;

	function automatic logic [WT_W-1:0] wbe_weight(input logic [WT_IDX_W-1:0] idx);
		logic [WT_W-1:0] w;
		case (idx)
			4'd0:    w = 18'd178145;
			4'd1:    w = 18'd65536;
			4'd2:    w = 18'd24109;
			4'd3:    w = 18'd8869;
			4'd4:    w = 18'd3263;
			4'd5:    w = 18'd1200;
			4'd6:    w = 18'd442;
			4'd7:    w = 18'd162;
			4'd8:    w = 18'd60;
			4'd9:    w = 18'd22;
			4'd10:   w = 18'd8;
			4'd11:   w = 18'd3;
			4'd12:   w = 18'd1;
			default: w = 18'd0;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== sv/wbe_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbe channel interfaces
// valid/ready channels for fragment items and estimate items
// ----------------------------------------------------------------------------
interface wbe_in_if
	import wbe_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic [BYTES_W-1:0] fragment_bytes;
	logic [NS_W-1:0]    download_ns;

	modport source (output valid, output fragment_bytes, output download_ns, input ready);
	modport sink   (input valid, input fragment_bytes, input download_ns, output ready);
endinterface

interface wbe_out_if
	import wbe_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [RATE_W-1:0] estimate_bps;
	logic              was_capped;

	modport source (output valid, output estimate_bps, output was_capped, input ready);
	modport sink   (input valid, input estimate_bps, input was_capped, output ready);
endinterface
`default_nettype wire

// ===== sv/wbe_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbe_sequencer
// step counter and microcode rom, conditional jumps on datapath flags
// ----------------------------------------------------------------------------
module wbe_sequencer
	import wbe_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  stat_t stat,
	output op_t   op
);

	localparam logic [PC_W-1:0] PC_LOAD  = 4'd0;
	localparam logic [PC_W-1:0] PC_DIV_R = 4'd3;
	localparam logic [PC_W-1:0] PC_PUSH  = 4'd4;
	localparam logic [PC_W-1:0] PC_MAC   = 4'd5;
	localparam logic [PC_W-1:0] PC_DIV_M = 4'd8;
	localparam logic [PC_W-1:0] PC_EMIT  = 4'd9;

	logic [PC_W-1:0] pc_q;
	ucode_t          uw;
	logic            take;

	always_comb begin
		unique case (pc_q)
			4'd0:    uw = '{OP_LOAD,       JC_IF_NO_IN,    PC_LOAD};
			4'd1:    uw = '{OP_MUL_RATE,   JC_NEXT,        PC_LOAD};
			4'd2:    uw = '{OP_RATE_SETUP, JC_IF_SAT,      PC_PUSH};
			4'd3:    uw = '{OP_DIV_STEP,   JC_IF_DIV_MORE, PC_DIV_R};
			4'd4:    uw = '{OP_PUSH,       JC_NEXT,        PC_LOAD};
			4'd5:    uw = '{OP_MAC_MUL,    JC_NEXT,        PC_LOAD};
			4'd6:    uw = '{OP_MAC_ADD,    JC_IF_MAC_MORE, PC_MAC};
			4'd7:    uw = '{OP_MEAN_SETUP, JC_NEXT,        PC_LOAD};
			4'd8:    uw = '{OP_DIV_STEP,   JC_IF_DIV_MORE, PC_DIV_M};
			4'd9:    uw = '{OP_EMIT,       JC_IF_OUT_BUSY, PC_EMIT};
			default: uw = '{OP_NOP,        JC_ALWAYS,      PC_LOAD};
		endcase
	end

	always_comb begin
		unique case (uw.jc)
			JC_NEXT:        take = 1'b0;
			JC_ALWAYS:      take = 1'b1;
			JC_IF_NO_IN:    take = !stat.in_pending;
			JC_IF_SAT:      take = stat.rate_sat;
			JC_IF_DIV_MORE: take = stat.div_more;
			JC_IF_MAC_MORE: take = stat.mac_more;
			JC_IF_OUT_BUSY: take = stat.out_busy;
			default:        take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_LOAD;
		end else if (take) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + 4'd1;
		end
	end

	assign op = uw.op;

endmodule
`default_nettype wire

// ===== sv/wbe_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbe_datapath
// rate multiplier, shared restoring divider, history ring, weighted
// accumulator, caps and output register
// ----------------------------------------------------------------------------
module wbe_datapath
	import wbe_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  op_t                   op,
	input  wire                   cfg_wr_en,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_W-1:0]       cfg_data,
	wbe_in_if.sink                fragment,
	wbe_out_if.source             estimate,
	output stat_t                 stat
);

	// configuration
	logic [CFG_W-1:0] link_cap_q;
	logic [CFG_W-1:0] max_cap_q;

	// item and rate
	logic [BYTES_W-1:0] bytes_q;
	logic [NS_W-1:0]    ns_q;
	logic [PROD_W-1:0]  prod_q;
	logic               sat_q;

	// divider
	logic [NS_W-1:0]   rem_q;
	logic [NS_W-1:0]   dvs_q;
	logic [RATE_W-1:0] dq_q;
	logic [DCNT_W-1:0] dcnt_q;

	// history ring
	logic [RATE_W-1:0] hist_q [WBE_DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] newest_q;
	logic [SLOT_W-1:0] rd_slot_q;
	logic [SLOT_W-1:0] idx_q;

	// weighted sum
	logic [MPROD_W-1:0] mprod_q;
	logic [WT_W-1:0]    wsel_q;
	logic [ACC_W-1:0]   acc_q;
	logic [DEN_W-1:0]   den_q;

	// output register
	logic              out_valid_q;
	logic [RATE_W-1:0] out_est_q;
	logic              out_capped_q;

	logic [RATE_W-1:0]      num_lo;
	logic [PROD_W-30:0]     num_hi;
	logic                   rate_sat;
	logic [NS_W:0]          shifted;
	logic                   fits;
	logic [SLOT_W-1:0]      push_slot;
	logic [RATE_W-1:0]      push_rate;
	logic [WT_W-1:0]        wt;
	logic                   out_busy;
	logic [RATE_W-1:0]      est_link;
	logic [RATE_W-1:0]      est_final;
	logic                   hit_link;
	logic                   hit_max;

	// numerator is prod_q << 3; split at bit 32
	assign num_hi   = prod_q[PROD_W-1:29];
	assign num_lo   = {prod_q[28:0], 3'b000};
	assign rate_sat = (ns_q == '0) || (NS_W'(num_hi) >= ns_q);

	assign shifted = {rem_q, dq_q[RATE_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	assign push_slot = (count_q == '0) ? '0 :
		(newest_q == SLOT_W'(WBE_DEPTH - 1)) ? '0 : newest_q + 1'b1;
	assign push_rate = sat_q ? '1 : dq_q;

	assign wt = wbe_weight(WT_IDX_W'(idx_q));

	assign out_busy = out_valid_q && !estimate.ready;

	always_comb begin
		est_link = dq_q;
		hit_link = 1'b0;
		hit_max  = 1'b0;
		if (link_cap_q != '0 && dq_q > link_cap_q) begin
			est_link = link_cap_q;
			hit_link = 1'b1;
		end
		est_final = est_link;
		if (max_cap_q != '0 && est_link > max_cap_q) begin
			est_final = max_cap_q;
			hit_max   = 1'b1;
		end
	end

	assign stat.in_pending = fragment.valid;
	assign stat.rate_sat   = rate_sat;
	assign stat.div_more   = dcnt_q != DCNT_W'(1);
	assign stat.mac_more   = CNT_W'(idx_q) < count_q - 1'b1;
	assign stat.out_busy   = out_busy;

	assign fragment.ready = (op == OP_LOAD);

	assign estimate.valid        = out_valid_q;
	assign estimate.estimate_bps = out_est_q;
	assign estimate.was_capped   = out_capped_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_cap_q  <= '0;
			max_cap_q   <= '0;
			count_q     <= '0;
			newest_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_LINK_SPEED_CAP: link_cap_q <= cfg_data;
					CFG_MAX_RATE_CAP:   max_cap_q  <= cfg_data;
					default:            ;
				endcase
			end
			if (op == OP_PUSH) begin
				newest_q <= push_slot;
				if (count_q < CNT_W'(WBE_DEPTH)) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (op == OP_EMIT && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (estimate.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// history ring, no reset
	always_ff @(posedge clk) begin
		if (op == OP_PUSH) begin
			hist_q[push_slot] <= push_rate;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				if (fragment.valid) begin
					bytes_q <= fragment.fragment_bytes;
					ns_q    <= fragment.download_ns;
				end
			end
			OP_MUL_RATE: begin
				prod_q <= PROD_W'(bytes_q) * PROD_W'(NS_PER_S);
			end
			OP_RATE_SETUP: begin
				sat_q  <= rate_sat;
				rem_q  <= NS_W'(num_hi);
				dvs_q  <= ns_q;
				dq_q   <= num_lo;
				dcnt_q <= DCNT_INIT;
			end
			OP_DIV_STEP: begin
				if (fits) begin
					rem_q <= NS_W'(shifted - {1'b0, dvs_q});
					dq_q  <= {dq_q[RATE_W-2:0], 1'b1};
				end else begin
					rem_q <= shifted[NS_W-1:0];
					dq_q  <= {dq_q[RATE_W-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 1'b1;
			end
			OP_PUSH: begin
				rd_slot_q <= push_slot;
				idx_q     <= '0;
				acc_q     <= '0;
				den_q     <= '0;
			end
			OP_MAC_MUL: begin
				mprod_q <= MPROD_W'(hist_q[rd_slot_q]) * MPROD_W'(wt);
				wsel_q  <= wt;
			end
			OP_MAC_ADD: begin
				acc_q     <= acc_q + ACC_W'(mprod_q);
				den_q     <= den_q + DEN_W'(wsel_q);
				idx_q     <= idx_q + 1'b1;
				rd_slot_q <= (rd_slot_q == '0) ? SLOT_W'(WBE_DEPTH - 1) : rd_slot_q - 1'b1;
			end
			OP_MEAN_SETUP: begin
				rem_q  <= NS_W'(acc_q[ACC_W-1:RATE_W]);
				dvs_q  <= NS_W'(den_q);
				dq_q   <= acc_q[RATE_W-1:0];
				dcnt_q <= DCNT_INIT;
			end
			OP_EMIT: begin
				if (!out_busy) begin
					out_est_q    <= est_final;
					out_capped_q <= hit_link || hit_max;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/weighted_bandwidth_estimator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_bandwidth_estimator_unit
// weighted mean of recent fragment download rates, capped by link speed
// and by a maximum rate
// ----------------------------------------------------------------------------
// usage
//   fragment: one item per completed download (byte count, duration in ns)
//   estimate: one item per fragment item (estimate in bit/s, cap flag)
//   cfg_*   : write-only registers, written while the unit is idle
//             index 0 link speed cap, index 1 maximum rate cap, 0 = no cap
// timing
//   one item at a time; fragment.ready is high only at the load step
//   each item makes two 32-step passes through the shared restoring
//   divider (rate, then mean) and a two-step multiply-accumulate per
//   stored rate (1..5); the rate pass is skipped when the rate saturates
// reset
//   history empty, caps zero, sequencer at the load step, no estimate
// stall
//   the estimate waits in its output register; the next fragment is still
//   taken and worked on, and its result holds at the emit step until the
//   register frees up
// ----------------------------------------------------------------------------
module weighted_bandwidth_estimator_unit
	import wbe_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	wbe_in_if.sink              fragment,
	wbe_out_if.source           estimate,
	input  wire                 cfg_wr_en,
	input  wire [CFG_IDX_W-1:0] cfg_index,
	input  wire [CFG_W-1:0]     cfg_data
);

	// current microcode operation
	op_t   op;
	// datapath flags for conditional jumps
	stat_t stat;

	// control program: load, rate divide, push, weighted sum, mean divide, emit
	wbe_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.op     (op)
	);

	// arithmetic, history ring and output register
	wbe_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fragment  (fragment),
		.estimate  (estimate),
		.stat      (stat)
	);

	// an accepted item starts the work; no second accept the next cycle
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		fragment.valid && fragment.ready |=> !fragment.ready)
		else $error("fragment accepted twice in a row");

	// a new estimate only comes out of the emit step
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(estimate.valid) |-> $past(op == OP_EMIT))
		else $error("estimate raised outside emit step");

	// a capped estimate is a nonzero cap value
	a_cap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		estimate.valid && estimate.was_capped |-> estimate.estimate_bps != '0)
		else $error("capped estimate is zero");

endmodule
`default_nettype wire
